// File: hdl/rc4sc_pkg.sv
// Shared types and constants for the RC4 stream cipher engine.
`timescale 1ns / 1ps

package rc4sc_pkg;

    // Table and key geometry
    localparam int TABLE_SIZE    = 256;
    localparam int MAX_KEY_BYTES = 32;
    localparam int KEY_WORDS     = 4;
    localparam int BYTE_W        = 8;
    localparam int KEY_LEN_W     = 6;
    localparam int KEY_IDX_W     = 5;
    localparam int WORD_W        = 64;
    localparam int CFG_IDX_W     = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = 3'd4;

    // Item modes
    localparam logic MODE_REKEY = 1'b0;
    localparam logic MODE_CRYPT = 1'b1;

    // Input item
    typedef struct packed {
        logic              mode;
        logic [BYTE_W-1:0] data_in;
    } t_in;

    // Result item
    typedef struct packed {
        logic [BYTE_W-1:0] data_out;
        logic              rekey_done;
    } t_out;

    // Permutation table access, one write and one read port
    typedef struct packed {
        logic              we;
        logic [BYTE_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic [BYTE_W-1:0] raddr;
    } t_mem_req;

endpackage

// File: hdl/rc4_stream_cipher_top.sv
// RC4 engine top level: one item at a time through a shared 8-bit table sequencer.
// Crypt: S_C_RJ, S_C_WI, S_C_WJ, then S_OUT hands the result to the output register;
//   the next item is taken only once that handover is done.
// Rekey: a table fill sweep, then S_K_RN, S_K_RJ, S_K_WN, S_K_WJ per entry, split so
//   the single read and write port suffice; a zero key length only clears the table.
// Reset (i_rst_n low, synchronous) clears indices and registers, then a clearing pass
//   zeroes the table while o_in_stall stays high.
`timescale 1ns / 1ps

module rc4_stream_cipher_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  rc4sc_pkg::t_in                      i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output rc4sc_pkg::t_out                     o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rc4sc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rc4sc_pkg::WORD_W-1:0]        i_cfg_data
);
    import rc4sc_pkg::*;

    logic [KEY_IDX_W-1:0] key_idx;
    logic [BYTE_W-1:0]    key_byte;
    logic [KEY_LEN_W-1:0] key_len;
    t_mem_req             mem_req;
    logic [BYTE_W-1:0]    mem_rdata;

    // Configuration registers
    rc4sc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_key_idx   (key_idx),
        .o_key_byte  (key_byte),
        .o_key_len   (key_len)
    );

    // Sequencer
    rc4sc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_key_len   (key_len),
        .i_key_byte  (key_byte),
        .o_key_idx   (key_idx),
        .o_mem_req   (mem_req),
        .i_mem_rdata (mem_rdata)
    );

    // Permutation table
    rc4sc_table u_table (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

endmodule

// File: hdl/rc4sc_table.sv
// Permutation table memory: 256 x 8, one write port, one registered read port.
`timescale 1ns / 1ps

module rc4sc_table (
    input  logic                                i_clk,
    input  rc4sc_pkg::t_mem_req                 i_req,
    output logic [rc4sc_pkg::BYTE_W-1:0]        o_rdata
);
    import rc4sc_pkg::*;

    logic [BYTE_W-1:0] r_mem [TABLE_SIZE];
    logic [BYTE_W-1:0] r_rdata;

    // Write first-port data, register the read (old data on same-address access)
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/rc4sc_cfg.sv
// Configuration registers: key length and key words, key byte selection.
`timescale 1ns / 1ps

module rc4sc_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [rc4sc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rc4sc_pkg::WORD_W-1:0]         i_cfg_data,
    input  logic [rc4sc_pkg::KEY_IDX_W-1:0]      i_key_idx,
    output logic [rc4sc_pkg::BYTE_W-1:0]         o_key_byte,
    output logic [rc4sc_pkg::KEY_LEN_W-1:0]      o_key_len
);
    import rc4sc_pkg::*;

    logic [KEY_LEN_W-1:0]            r_key_len;
    logic [KEY_WORDS-1:0][WORD_W-1:0] r_key_word;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_len  <= '0;
            r_key_word <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_KEY_LENGTH: r_key_len     <= i_cfg_data[KEY_LEN_W-1:0];
                REG_KEY_WORD_0: r_key_word[0] <= i_cfg_data;
                REG_KEY_WORD_1: r_key_word[1] <= i_cfg_data;
                REG_KEY_WORD_2: r_key_word[2] <= i_cfg_data;
                REG_KEY_WORD_3: r_key_word[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Saturate the key length to the key buffer size
    assign o_key_len = (r_key_len > KEY_LEN_W'(MAX_KEY_BYTES)) ?
                       KEY_LEN_W'(MAX_KEY_BYTES) : r_key_len;

    // Pick key byte: word from the upper index bits, byte lane from the lower
    assign o_key_byte = r_key_word[i_key_idx[KEY_IDX_W-1:3]][i_key_idx[2:0]*BYTE_W +: BYTE_W];

endmodule

// File: hdl/rc4sc_ctrl.sv
// Sequencer: table sweeps, key schedule, keystream steps and result register.
`timescale 1ns / 1ps

module rc4sc_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  rc4sc_pkg::t_in                      i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output rc4sc_pkg::t_out                     o_out_data,
    input  logic [rc4sc_pkg::KEY_LEN_W-1:0]     i_key_len,
    input  logic [rc4sc_pkg::BYTE_W-1:0]        i_key_byte,
    output logic [rc4sc_pkg::KEY_IDX_W-1:0]     o_key_idx,
    output rc4sc_pkg::t_mem_req                 o_mem_req,
    input  logic [rc4sc_pkg::BYTE_W-1:0]        i_mem_rdata
);
    import rc4sc_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_FILL = 4'd1;
    localparam logic [3:0] S_K_RN = 4'd2;
    localparam logic [3:0] S_K_RJ = 4'd3;
    localparam logic [3:0] S_K_WN = 4'd4;
    localparam logic [3:0] S_K_WJ = 4'd5;
    localparam logic [3:0] S_C_RJ = 4'd6;
    localparam logic [3:0] S_C_WI = 4'd7;
    localparam logic [3:0] S_C_WJ = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    localparam logic [BYTE_W-1:0] LAST_ENTRY = BYTE_W'(TABLE_SIZE - 1);

    logic [3:0]           r_state, n_state;
    logic [BYTE_W-1:0]    r_n, n_n;
    logic [KEY_IDX_W-1:0] r_k, n_k;
    logic [BYTE_W-1:0]    r_i, n_i;
    logic [BYTE_W-1:0]    r_j, n_j;
    logic [BYTE_W-1:0]    r_si, n_si;
    logic [BYTE_W-1:0]    r_sj, n_sj;
    logic [BYTE_W-1:0]    r_t, n_t;
    logic [BYTE_W-1:0]    r_data, n_data;
    logic                 r_ident, n_ident;
    logic                 r_rekey, n_rekey;
    t_out                 r_res, n_res;
    t_out                 r_out, n_out;
    logic                 r_out_valid, n_out_valid;

    logic                 in_accept;
    logic [BYTE_W-1:0]    add_a;
    logic [BYTE_W-1:0]    add_k;
    logic [BYTE_W-1:0]    sum;
    logic [BYTE_W-1:0]    ks;
    logic [BYTE_W-1:0]    i_next;
    t_mem_req             req;

    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign i_next     = r_i + BYTE_W'(1);

    // Shared adder: index update, key schedule step and keystream address
    assign add_a = (r_state == S_C_WI) ? r_si : r_j;
    assign add_k = (r_state == S_K_RJ) ? i_key_byte : '0;
    assign sum   = add_a + i_mem_rdata + add_k;

    // Keystream byte after the swap: forward the entries just written
    assign ks = (r_t == r_j) ? r_si :
                (r_t == r_i) ? r_sj : i_mem_rdata;

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_k         = r_k;
        n_i         = r_i;
        n_j         = r_j;
        n_si        = r_si;
        n_sj        = r_sj;
        n_t         = r_t;
        n_data      = r_data;
        n_ident     = r_ident;
        n_rekey     = r_rekey;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        req         = '0;
        req.raddr   = r_n;

        unique case (r_state)
            S_IDLE: begin
                // Start a rekey sweep or the first keystream read
                req.raddr = i_next;
                if (in_accept) begin
                    n_data = i_in_data.data_in;
                    if (i_in_data.mode == MODE_REKEY) begin
                        n_rekey = 1'b1;
                        n_ident = (i_key_len != '0);
                        n_n     = '0;
                        n_k     = '0;
                        n_i     = '0;
                        n_j     = '0;
                        n_state = S_FILL;
                    end else begin
                        n_i     = i_next;
                        n_state = S_C_RJ;
                    end
                end
            end
            S_FILL: begin
                // Write identity or zero, one entry a cycle
                req.we    = 1'b1;
                req.waddr = r_n;
                req.wdata = r_ident ? r_n : '0;
                n_n       = r_n + BYTE_W'(1);
                if (r_n == LAST_ENTRY) begin
                    if (r_rekey && r_ident) begin
                        n_state = S_K_RN;
                    end else if (r_rekey) begin
                        n_res   = '{data_out: '0, rekey_done: 1'b1};
                        n_state = S_OUT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_K_RN: begin
                req.raddr = r_n;
                n_state   = S_K_RJ;
            end
            S_K_RJ: begin
                // j += S[n] + key byte; fetch S[j]
                n_si      = i_mem_rdata;
                n_j       = sum;
                req.raddr = sum;
                n_state   = S_K_WN;
            end
            S_K_WN: begin
                req.we    = 1'b1;
                req.waddr = r_n;
                req.wdata = i_mem_rdata;
                n_state   = S_K_WJ;
            end
            S_K_WJ: begin
                // Finish the swap, advance the table and key indexes
                req.we    = 1'b1;
                req.waddr = r_j;
                req.wdata = r_si;
                n_n       = r_n + BYTE_W'(1);
                n_k       = (({1'b0, r_k} + KEY_LEN_W'(1)) == i_key_len) ?
                            '0 : r_k + KEY_IDX_W'(1);
                if (r_n == LAST_ENTRY) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_res   = '{data_out: '0, rekey_done: 1'b1};
                    n_state = S_OUT;
                end else begin
                    n_state = S_K_RN;
                end
            end
            S_C_RJ: begin
                // j += S[i]; fetch S[j]
                n_si      = i_mem_rdata;
                n_j       = sum;
                req.raddr = sum;
                n_state   = S_C_WI;
            end
            S_C_WI: begin
                // S[i] = S[j]; fetch S[S[i] + S[j]] from the pre-swap table
                n_sj      = i_mem_rdata;
                req.we    = 1'b1;
                req.waddr = r_i;
                req.wdata = i_mem_rdata;
                req.raddr = sum;
                n_t       = sum;
                n_state   = S_C_WJ;
            end
            S_C_WJ: begin
                req.we    = 1'b1;
                req.waddr = r_j;
                req.wdata = r_si;
                n_res     = '{data_out: r_data ^ ks, rekey_done: 1'b0};
                n_state   = S_OUT;
            end
            S_OUT: begin
                // Hand the result over once the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_rekey     = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state; reset starts the clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_n         <= '0;
            r_k         <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_ident     <= 1'b0;
            r_rekey     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_n         <= n_n;
            r_k         <= n_k;
            r_i         <= n_i;
            r_j         <= n_j;
            r_ident     <= n_ident;
            r_rekey     <= n_rekey;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_si   <= n_si;
        r_sj   <= n_sj;
        r_t    <= n_t;
        r_data <= n_data;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_mem_req   = req;
    assign o_key_idx   = r_k;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: hdl/rc4sc_checker.sv
// Port-level checks for the RC4 engine, bound to the top level.
`timescale 1ns / 1ps

module rc4sc_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                o_in_stall,
    input  rc4sc_pkg::t_in                      i_in_data,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  rc4sc_pkg::t_out                     o_out_data,
    input  logic                                i_cfg_valid,
    input  logic                                o_cfg_ready,
    input  logic [rc4sc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rc4sc_pkg::WORD_W-1:0]        i_cfg_data
);
    import rc4sc_pkg::*;

    logic in_xfer;
    assign in_xfer = i_in_valid && !o_in_stall;

    // One item at a time: the input closes right after a transfer
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_in_stall)
        else $error("input taken while an item is in flight");

    // No result can be produced in the cycle after a transfer
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !$rose(o_out_valid))
        else $error("result appeared too early");

    // Rekey acknowledgements carry a zero data byte
    a_rekey_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.rekey_done) |-> (o_out_data.data_out == '0))
        else $error("rekey result with nonzero data");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

endmodule

bind rc4_stream_cipher_top rc4sc_checker u_checker (.*);

// File: test/rc4_stream_cipher_top_tb.sv
// Self-checking testbench for the RC4 stream cipher top level with a built-in cipher predictor.
`timescale 1ns / 1ps

module rc4_stream_cipher_top_tb;
    import rc4sc_pkg::*;

    // First register index that maps to no register; writes there are dropped
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 3'd5;
    localparam int HOLDOFF_CYCLES = 600;
    localparam int DRAIN_CYCLES   = 20;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in                  i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out                 o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [WORD_W-1:0]    i_cfg_data = '0;

    // Cipher state mirrored by the predictor
    logic [BYTE_W-1:0]    sbox [TABLE_SIZE];
    logic [BYTE_W-1:0]    ks_i;
    logic [BYTE_W-1:0]    ks_j;
    logic [KEY_LEN_W-1:0] key_len_reg;
    logic [WORD_W-1:0]    key_word_reg [KEY_WORDS];

    t_in  cipher_items_queued [$];
    t_out cipher_results_due [$];

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    bit   holdoff_arm = 1'b0;
    logic hold_rx = 1'b0;
    int   mismatch_count = 0;

    wire in_xfer  = i_in_valid && !o_in_stall;
    wire out_xfer = o_out_valid && !i_out_stall;

    rc4_stream_cipher_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Mirror a register write; unknown indexes are dropped
    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [WORD_W-1:0] val);
        case (idx)
            REG_KEY_LENGTH: key_len_reg = val[KEY_LEN_W-1:0];
            REG_KEY_WORD_0: key_word_reg[0] = val;
            REG_KEY_WORD_1: key_word_reg[1] = val;
            REG_KEY_WORD_2: key_word_reg[2] = val;
            REG_KEY_WORD_3: key_word_reg[3] = val;
            default: ;
        endcase
    endfunction

    // Key schedule; a zero length leaves the table all zero
    function automatic void run_key_schedule();
        int len;
        int k;
        logic [BYTE_W-1:0] j;
        logic [BYTE_W-1:0] swap;
        len = (key_len_reg > MAX_KEY_BYTES) ? MAX_KEY_BYTES : int'(key_len_reg);
        ks_i = '0;
        ks_j = '0;
        j = '0;
        for (int n = 0; n < TABLE_SIZE; n++) sbox[n] = (len == 0) ? 8'h00 : n[7:0];
        if (len != 0) begin
            for (int n = 0; n < TABLE_SIZE; n++) begin
                k = n % len;
                j = j + sbox[n] + key_word_reg[k / 8][(k % 8) * 8 +: 8];
                swap = sbox[n];
                sbox[n] = sbox[j];
                sbox[j] = swap;
            end
        end
    endfunction

    // Expected result of one item; advances the mirrored state
    function automatic t_out cipher_step(input t_in item);
        t_out res;
        logic [BYTE_W-1:0] swap;
        logic [BYTE_W-1:0] ks_addr;
        if (item.mode == MODE_REKEY) begin
            run_key_schedule();
            res.data_out = '0;
            res.rekey_done = 1'b1;
        end else begin
            ks_i = ks_i + 8'd1;
            ks_j = ks_j + sbox[ks_i];
            swap = sbox[ks_i];
            sbox[ks_i] = sbox[ks_j];
            sbox[ks_j] = swap;
            ks_addr = sbox[ks_i] + sbox[ks_j];
            res.data_out = item.data_in ^ sbox[ks_addr];
            res.rekey_done = 1'b0;
        end
        return res;
    endfunction

    // Input driver: offer queued items, hold a stalled one, predict on transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                cipher_results_due.push_back(cipher_step(cipher_items_queued.pop_front()));
            end
            if (!i_in_valid || in_xfer) begin
                if (cipher_items_queued.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= cipher_items_queued[0];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each transfer against the oldest prediction
    always @(posedge i_clk) begin : result_monitor
        t_out want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (out_xfer) begin
                if (cipher_results_due.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $time, o_out_data);
                    mismatch_count++;
                end else begin
                    want = cipher_results_due.pop_front();
                    if (o_out_data.data_out !== want.data_out) begin
                        $display("%0t: data_out mismatch, expected %h actual %h",
                                 $time, want.data_out, o_out_data.data_out);
                        mismatch_count++;
                    end
                    if (o_out_data.rekey_done !== want.rekey_done) begin
                        $display("%0t: rekey_done mismatch, expected %b actual %b",
                                 $time, want.rekey_done, o_out_data.rekey_done);
                        mismatch_count++;
                    end
                end
            end
            i_out_stall <= hold_rx || ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Long receiver hold-off so the block fills up and stalls its input
    initial begin : rx_holdoff
        wait (holdoff_arm);
        @(posedge i_clk);
        hold_rx <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    initial begin
        #(30_000_000);
        $display("rc4_stream_cipher_top_tb failed");
        $finish;
    end

    task automatic push_item(input logic mode, input logic [BYTE_W-1:0] data);
        t_in item;
        item.mode = mode;
        item.data_in = data;
        cipher_items_queued.push_back(item);
    endtask

    // Wait until every item went in and every result came out
    task automatic wait_idle();
        while (cipher_items_queued.size() != 0 || cipher_results_due.size() != 0)
            @(posedge i_clk);
    endtask

    // One register write; valid stays high for a following write
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg_write(idx, val);
    endtask

    // Write all key registers once the block is idle, optionally poke unused indexes
    task automatic load_key(input logic [WORD_W-1:0] len_word, input logic [WORD_W-1:0] w0,
                            input logic [WORD_W-1:0] w1, input logic [WORD_W-1:0] w2,
                            input logic [WORD_W-1:0] w3, input bit poke_unused);
        wait_idle();
        @(posedge i_clk);
        cfg_write(REG_KEY_LENGTH, len_word);
        cfg_write(REG_KEY_WORD_0, w0);
        cfg_write(REG_KEY_WORD_1, w1);
        cfg_write(REG_KEY_WORD_2, w2);
        cfg_write(REG_KEY_WORD_3, w3);
        if (poke_unused) begin
            for (int k = 0; k < 3; k++)
                cfg_write(REG_FIRST_UNUSED + k[CFG_IDX_W-1:0], {$urandom, $urandom});
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Random key, a first rekey, then mostly crypt items with an occasional rekey
    task automatic random_phase(input int send_pct, input int recv_pct, input int count,
                                input bit long_hold);
        logic [WORD_W-1:0] len_word;
        len_word = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       len_word[KEY_LEN_W-1:0] = '0;
            1:       len_word[KEY_LEN_W-1:0] = 6'($urandom_range(33, 63));
            default: len_word[KEY_LEN_W-1:0] = 6'($urandom_range(1, MAX_KEY_BYTES));
        endcase
        load_key(len_word, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom}, $urandom_range(0, 1));
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        push_item(MODE_REKEY, 8'($urandom));
        repeat (count)
            push_item(($urandom_range(99) < 4) ? MODE_REKEY : MODE_CRYPT, 8'($urandom));
        if (long_hold) holdoff_arm = 1'b1;
    endtask

    initial begin : stimulus
        for (int n = 0; n < TABLE_SIZE; n++) sbox[n] = '0;
        ks_i = '0;
        ks_j = '0;
        key_len_reg = '0;
        for (int n = 0; n < KEY_WORDS; n++) key_word_reg[n] = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Crypt on the cleared table passes data through
        push_item(MODE_CRYPT, 8'h00);
        push_item(MODE_CRYPT, 8'hFF);
        // Rekey with the reset key length of zero
        push_item(MODE_REKEY, 8'hFF);
        push_item(MODE_CRYPT, 8'hA5);

        // Short key, unused register indexes written too
        load_key(64'd5, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
        push_item(MODE_REKEY, 8'h00);
        push_item(MODE_CRYPT, 8'h00);
        push_item(MODE_CRYPT, 8'hFF);
        push_item(MODE_CRYPT, 8'h3C);

        // Longest key, all-ones and all-zero key bytes
        load_key(64'd32, '1, '0, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
        push_item(MODE_REKEY, 8'h5A);
        push_item(MODE_CRYPT, 8'h00);
        push_item(MODE_CRYPT, 8'hFF);

        // Length above the maximum saturates; upper data bits ignored
        load_key('1, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, '1, 1'b0);
        push_item(MODE_REKEY, 8'h00);
        push_item(MODE_CRYPT, 8'h80);
        push_item(MODE_CRYPT, 8'h7F);

        // Zero length after a live table clears it again
        load_key(64'd0, key_word_reg[0], key_word_reg[1], key_word_reg[2],
                 key_word_reg[3], 1'b0);
        push_item(MODE_REKEY, 8'h00);
        push_item(MODE_CRYPT, 8'hC3);

        // Single zero key byte
        load_key(64'd1, '0, '0, '0, '0, 1'b0);
        push_item(MODE_REKEY, 8'h00);
        push_item(MODE_CRYPT, 8'h00);
        push_item(MODE_CRYPT, 8'hFF);

        random_phase(0, 0, 270, 1'b0);
        random_phase(45, 0, 270, 1'b0);
        random_phase(0, 45, 270, 1'b1);
        random_phase(36, 36, 270, 1'b0);
        random_phase(0, 0, 270, 1'b0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("rc4_stream_cipher_top_tb passed");
        end else begin
            $display("rc4_stream_cipher_top_tb failed");
        end
        $finish;
    end

endmodule
